// File: rtl/lruk_pkg.sv
// Shared types, widths and codes for the LRU-K victim selector.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package lruk_pkg;

   // Geometry
   localparam int FRAMES_MAX  = 64;
   localparam int K_MAX       = 8;
   localparam int FRAME_W     = $clog2(FRAMES_MAX);
   localparam int FRAME_CNT_W = $clog2(FRAMES_MAX + 1);
   localparam int SLOT_W      = $clog2(K_MAX);
   localparam int COUNT_W     = $clog2(K_MAX + 1);
   localparam int HIST_ADDR_W = FRAME_W + SLOT_W;
   localparam int HIST_DEPTH  = FRAMES_MAX * K_MAX;
   localparam int TIME_W      = 48;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // Word fields
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   // Configuration registers
   localparam int DEPTH_W    = 4;
   localparam int FRAMES_W   = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_HISTORY_DEPTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd1;

   localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 4'd2;
   localparam logic [FRAMES_W-1:0] FRAMES_RESET = 7'd64;

   // Operation codes
   localparam logic [OP_W-1:0] OP_RECORD      = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_EVICT   = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_EVICT = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE      = 3'd3;
   localparam logic [OP_W-1:0] OP_EVICT       = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_VICTIM  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_EVICT  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RNG = 2'd3;

   // Per-frame ring bookkeeping
   typedef struct packed {
      logic [SLOT_W-1:0]  head;
      logic [COUNT_W-1:0] count;
   } meta_type;

   // Commands into the bookkeeping store
   typedef struct packed {
      logic               rd_en;
      logic [FRAME_W-1:0] rd_addr;
      logic               wr_en;
      logic [FRAME_W-1:0] wr_addr;
      meta_type           wr_data;
      logic               clr_en;
      logic [FRAME_W-1:0] clr_addr;
   } meta_cmd_type;

   // Commands into the history RAM
   typedef struct packed {
      logic                   en;
      logic                   we;
      logic [HIST_ADDR_W-1:0] addr;
      logic [TIME_W-1:0]      wdata;
   } hist_cmd_type;

   // One frame moving through the scan pipeline
   typedef struct packed {
      logic               valid;
      logic               evictable;
      logic               short_hist;
      logic [FRAME_W-1:0] frame;
   } scan_beat_type;

endpackage

`default_nettype wire

// File: rtl/lruk_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on lruk_pkg for field widths.
`default_nettype none

interface lruk_req_if;
   import lruk_pkg::*;
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [FRAME_W-1:0] frame;
   modport source (output valid, operation, frame, input ready);
   modport sink   (input valid, operation, frame, output ready);
endinterface

interface lruk_rsp_if;
   import lruk_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FRAME_W-1:0]  victim_frame;
   modport source (output valid, status, victim_frame, input ready);
   modport sink   (input valid, status, victim_frame, output ready);
endinterface

interface lruk_csr_if;
   import lruk_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/lru_k_victim_selector_top.sv
// LRU-K victim selector. One request word in flight at a time.
// An evict scans limit frames (limit = frames_in_use capped at 64), one frame per cycle,
// through bookkeeping store, history RAM and compare. The next word is taken once the
// response register loads; a response held by the receiver stalls the request side.
// Reset (synchronous, active high): all frames not evictable with empty history, time
// at zero, K = 2, 64 frames. No clearing pass.
`default_nettype none

module lru_k_victim_selector_top
   import lruk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lruk_req_if.sink   req_port,
   lruk_rsp_if.source rsp_port,
   lruk_csr_if.sink   csr_port
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REC,
      ST_SCAN,
      ST_FINISH,
      ST_RESP
   } state_type;

   state_type state_ff;

   // Configuration registers
   logic [DEPTH_W-1:0]  history_depth_ff;
   logic [FRAMES_W-1:0] frames_in_use_ff;

   // Latched request word and its view of the configuration
   logic [FRAME_W-1:0]     frame_ff;
   logic [COUNT_W-1:0]     k_ff;
   logic [FRAME_CNT_W-1:0] limit_ff;

   // Policy state held in flops
   logic [FRAMES_MAX-1:0] evictable_ff;
   logic [TIME_W-1:0]     time_counter_ff;

   // Scan sequencer
   logic [FRAME_CNT_W-1:0] scan_idx_ff;
   scan_beat_type          s1_ff;
   scan_beat_type          s2_ff;
   scan_beat_type          s1_in;
   scan_beat_type          s2_in;
   logic                   scan_issue;

   // Result held until the response register frees up
   logic [STATUS_W-1:0] pend_status_ff;
   logic [FRAME_W-1:0]  pend_victim_ff;

   // Response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [FRAME_W-1:0]  rsp_victim_ff;
   logic                rsp_load;

   // Decode of an accepted word
   state_type           accept_state;
   logic [STATUS_W-1:0] accept_status;

   // Helpers
   logic                   req_ready;
   logic                   req_fire;
   logic [COUNT_W-1:0]     k_now;
   logic [FRAME_CNT_W-1:0] limit_now;
   logic                   in_range;
   logic [COUNT_W-1:0]     head_ext;
   logic [COUNT_W-1:0]     slot_wide;
   logic [SLOT_W-1:0]      kth_slot;
   logic [SLOT_W-1:0]      head_next;
   logic [COUNT_W-1:0]     count_next;
   logic                   track_found;
   logic [FRAME_W-1:0]     track_frame;

   meta_cmd_type      meta_cmd;
   meta_type          meta_rd;
   hist_cmd_type      hist_cmd;
   logic [TIME_W-1:0] hist_rd;

   //------------------------------------------------------------------
   // Register writes: always accepted, taken only while idle by contract.
   //------------------------------------------------------------------
   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         history_depth_ff <= DEPTH_RESET;
         frames_in_use_ff <= FRAMES_RESET;
      end else if (csr_port.valid) begin
         case (csr_port.index)
            REG_HISTORY_DEPTH: history_depth_ff <= csr_port.data[DEPTH_W-1:0];
            REG_FRAMES_IN_USE: frames_in_use_ff <= csr_port.data[FRAMES_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp K into 1..K_MAX and the frame limit to FRAMES_MAX.
   always_comb begin
      if (history_depth_ff == '0) begin
         k_now = COUNT_W'(1);
      end else if (COUNT_W'(history_depth_ff) > COUNT_W'(K_MAX)) begin
         k_now = COUNT_W'(K_MAX);
      end else begin
         k_now = COUNT_W'(history_depth_ff);
      end
   end

   assign limit_now = (FRAME_CNT_W'(frames_in_use_ff) > FRAME_CNT_W'(FRAMES_MAX)) ?
                      FRAME_CNT_W'(FRAMES_MAX) : FRAME_CNT_W'(frames_in_use_ff);

   assign req_ready       = (state_ff == ST_IDLE);
   assign req_port.ready  = req_ready;
   assign req_fire        = req_port.valid && req_ready;
   assign in_range        = (FRAME_CNT_W'(req_port.frame) < limit_now);

   // Pick the follow-on state and the early status of an incoming word.
   always_comb begin
      accept_state  = ST_RESP;
      accept_status = STATUS_DONE;
      case (req_port.operation)
         OP_RECORD: begin
            if (in_range) begin
               accept_state = ST_REC;
            end else begin
               accept_status = STATUS_OUT_OF_RNG;
            end
         end
         OP_SET_EVICT, OP_CLEAR_EVICT: begin
            if (!in_range) begin
               accept_status = STATUS_OUT_OF_RNG;
            end
         end
         OP_REMOVE: begin
            if (!in_range) begin
               accept_status = STATUS_OUT_OF_RNG;
            end else if (!evictable_ff[req_port.frame]) begin
               accept_status = STATUS_NOT_EVICT;
            end
         end
         OP_EVICT: begin
            accept_state = ST_SCAN;
         end
         default: ;
      endcase
   end

   //------------------------------------------------------------------
   // Ring arithmetic on the bookkeeping word read back from the store.
   //------------------------------------------------------------------
   assign head_ext   = COUNT_W'(meta_rd.head);
   assign slot_wide  = (head_ext >= k_ff) ? (head_ext - k_ff)
                                          : (head_ext + COUNT_W'(K_MAX) - k_ff);
   assign kth_slot   = slot_wide[SLOT_W-1:0];
   assign head_next  = (meta_rd.head == SLOT_W'(K_MAX - 1)) ? '0 : (meta_rd.head + 1'b1);
   assign count_next = (meta_rd.count < COUNT_W'(K_MAX)) ? (meta_rd.count + 1'b1)
                                                         : meta_rd.count;

   assign scan_issue = (state_ff == ST_SCAN) && (scan_idx_ff < limit_ff);

   // Scan pipeline: issue bookkeeping read, then history read, then compare.
   always_comb begin
      s1_in            = '0;
      s1_in.valid      = scan_issue;
      s1_in.frame      = scan_idx_ff[FRAME_W-1:0];
      s1_in.evictable  = evictable_ff[scan_idx_ff[FRAME_W-1:0]];
      s2_in            = s1_ff;
      s2_in.short_hist = (meta_rd.count < k_ff);
   end

   // Bookkeeping store port control
   always_comb begin
      meta_cmd = '0;
      if (req_fire && (req_port.operation == OP_RECORD) && in_range) begin
         meta_cmd.rd_en   = 1'b1;
         meta_cmd.rd_addr = req_port.frame;
      end
      if (scan_issue) begin
         meta_cmd.rd_en   = 1'b1;
         meta_cmd.rd_addr = scan_idx_ff[FRAME_W-1:0];
      end
      if (state_ff == ST_REC) begin
         meta_cmd.wr_en         = 1'b1;
         meta_cmd.wr_addr       = frame_ff;
         meta_cmd.wr_data.head  = head_next;
         meta_cmd.wr_data.count = count_next;
      end
      // Dropping the valid bit empties the frame's history.
      if (req_fire && (req_port.operation == OP_REMOVE) && in_range &&
          evictable_ff[req_port.frame]) begin
         meta_cmd.clr_en   = 1'b1;
         meta_cmd.clr_addr = req_port.frame;
      end
      if ((state_ff == ST_FINISH) && track_found) begin
         meta_cmd.clr_en   = 1'b1;
         meta_cmd.clr_addr = track_frame;
      end
   end

   // History RAM port control: stamp on record, fetch K-th stamp on scan.
   always_comb begin
      hist_cmd = '0;
      if (state_ff == ST_REC) begin
         hist_cmd.en    = 1'b1;
         hist_cmd.we    = 1'b1;
         hist_cmd.addr  = {frame_ff, meta_rd.head};
         hist_cmd.wdata = time_counter_ff;
      end else if ((state_ff == ST_SCAN) && s1_ff.valid) begin
         hist_cmd.en    = 1'b1;
         hist_cmd.addr  = {s1_ff.frame, kth_slot};
      end
   end

   lruk_meta_store u_meta (
      .clock   (clock),
      .reset   (reset),
      .cmd     (meta_cmd),
      .rd_data (meta_rd)
   );

   lruk_hist_ram u_hist (
      .clock   (clock),
      .cmd     (hist_cmd),
      .rd_data (hist_rd)
   );

   lruk_best_track u_track (
      .clock      (clock),
      .reset      (reset),
      .start      (req_fire),
      .beat       (s2_ff),
      .beat_time  (hist_rd),
      .found      (track_found),
      .best_frame (track_frame)
   );

   // Load the response register when it is empty or being drained.
   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_port.ready);

   //------------------------------------------------------------------
   // Sequencer: state, policy flops and the response register.
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         evictable_ff    <= '0;
         time_counter_ff <= '0;
         scan_idx_ff     <= '0;
         s1_ff           <= '0;
         s2_ff           <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;

         // Load a new response, or drop the current one once taken.
         if (rsp_load) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= pend_status_ff;
            rsp_victim_ff <= pend_victim_ff;
         end else if (rsp_valid_ff && rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  frame_ff       <= req_port.frame;
                  k_ff           <= k_now;
                  limit_ff       <= limit_now;
                  scan_idx_ff    <= '0;
                  pend_status_ff <= accept_status;
                  pend_victim_ff <= '0;
                  state_ff       <= accept_state;
                  if (in_range) begin
                     case (req_port.operation)
                        OP_SET_EVICT:   evictable_ff[req_port.frame] <= 1'b1;
                        OP_CLEAR_EVICT: evictable_ff[req_port.frame] <= 1'b0;
                        default: ;
                     endcase
                  end
               end
            end

            ST_REC: begin
               // Advance logical time, holding at its maximum.
               if (time_counter_ff != TIME_MAX) begin
                  time_counter_ff <= time_counter_ff + 1'b1;
               end
               state_ff <= ST_RESP;
            end

            ST_SCAN: begin
               if (scan_issue) begin
                  scan_idx_ff <= scan_idx_ff + 1'b1;
               end else if (!s1_ff.valid && !s2_ff.valid) begin
                  state_ff <= ST_FINISH;
               end
            end

            ST_FINISH: begin
               if (track_found) begin
                  pend_victim_ff <= track_frame;
               end else begin
                  pend_status_ff <= STATUS_NO_VICTIM;
               end
               state_ff <= ST_RESP;
            end

            ST_RESP: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.status       = rsp_status_ff;
   assign rsp_port.victim_frame = rsp_victim_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------

   // One word in flight: after an accept, the request side stays closed.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while previous word still in flight");

   // Only a successful evict names a victim.
   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_DONE) |-> (rsp_victim_ff == '0))
      else $error("victim frame nonzero on a failing response");

   // Compare beats only flow while scanning.
   a_beat_in_scan: assert property (@(posedge clock) disable iff (reset)
      s2_ff.valid |-> (state_ff == ST_SCAN))
      else $error("scan beat outside scan state");

   // Logical time never runs backward.
   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (time_counter_ff >= $past(time_counter_ff)))
      else $error("time counter decreased");

   // Time only moves on a recorded access.
   a_time_on_record: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(state_ff != ST_REC) |-> $stable(time_counter_ff))
      else $error("time counter moved outside a record");

endmodule

`default_nettype wire

// File: rtl/lruk_hist_ram.sv
// Access-time history RAM: one ring of K_MAX stamps per frame, single port.
// Depends on lruk_pkg. Contents are undefined until written.
`default_nettype none

module lruk_hist_ram
   import lruk_pkg::*;
(
   input  logic              clock,
   input  hist_cmd_type      cmd,
   output logic [TIME_W-1:0] rd_data
);

   logic [TIME_W-1:0] mem [HIST_DEPTH];
   logic [TIME_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         if (cmd.we) begin
            mem[cmd.addr] <= cmd.wdata;
         end else begin
            rd_data_ff <= mem[cmd.addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lruk_meta_store.sv
// Per-frame ring head and access count, with a valid bit per frame so that
// reset and history clears read back as zero. Depends on lruk_pkg.
`default_nettype none

module lruk_meta_store
   import lruk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  meta_cmd_type cmd,
   output meta_type     rd_data
);

   meta_type                mem [FRAMES_MAX];
   logic [FRAMES_MAX-1:0]   valid_ff;
   meta_type                rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= valid_ff[cmd.rd_addr] ? mem[cmd.rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (cmd.wr_en) begin
            valid_ff[cmd.wr_addr] <= 1'b1;
         end
         if (cmd.clr_en) begin
            valid_ff[cmd.clr_addr] <= 1'b0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lruk_best_track.sv
// Compare unit of the victim scan: keeps the first short-history frame
// or else the oldest K-th stamp, later index on a tie. Depends on lruk_pkg.
`default_nettype none

module lruk_best_track
   import lruk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  scan_beat_type      beat,
   input  logic [TIME_W-1:0]  beat_time,
   output logic               found,
   output logic [FRAME_W-1:0] best_frame
);

   logic               found_short_ff;
   logic               found_any_ff;
   logic [FRAME_W-1:0] best_frame_ff;
   logic [TIME_W-1:0]  best_time_ff;
   logic               candidate;
   logic               take_short;
   logic               take_old;

   assign candidate  = beat.valid && beat.evictable && !found_short_ff;
   assign take_short = candidate && beat.short_hist;
   assign take_old   = candidate && !beat.short_hist &&
                       (!found_any_ff || (beat_time <= best_time_ff));

   always_ff @(posedge clock) begin
      if (reset || start) begin
         found_short_ff <= 1'b0;
         found_any_ff   <= 1'b0;
      end else begin
         if (take_short) begin
            found_short_ff <= 1'b1;
            best_frame_ff  <= beat.frame;
         end else if (take_old) begin
            found_any_ff  <= 1'b1;
            best_frame_ff <= beat.frame;
            best_time_ff  <= beat_time;
         end
      end
   end

   assign found      = found_short_ff || found_any_ff;
   assign best_frame = best_frame_ff;

endmodule

`default_nettype wire
